@@ design/assert_macros.svh @@
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Clocked assertion that also holds across reset.
`define ASSERT_ALL(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

@@ design/itoa_pkg.sv @@
// Package with the types, codes and character table of the radix formatter.
package itoa_pkg;

   localparam logic [2:0] MODE_SDEC = 3'd0;
   localparam logic [2:0] MODE_UDEC = 3'd1;
   localparam logic [2:0] MODE_OCT  = 3'd2;
   localparam logic [2:0] MODE_HEX  = 3'd3;
   localparam logic [2:0] MODE_PTR  = 3'd4;

   localparam logic [7:0] CHAR_MINUS = 8'h2d;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_X     = 8'h78;

   // Reciprocal of ten scaled by 2^35; exact quotient for every 32-bit value.
   localparam logic [31:0] DEC_RECIP = 32'hcccc_cccd;
   localparam int          DEC_SHIFT = 35;

   localparam int STACK_DEPTH = 16;
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      RADIX_DEC,
      RADIX_OCT,
      RADIX_HEX
   } radix_type;

   typedef enum logic [1:0] {
      PFX_NONE,
      PFX_MINUS,
      PFX_HEX
   } prefix_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONV,
      ST_SIGN,
      ST_ZERO,
      ST_XCHR,
      ST_DIGITS
   } back_state_type;

   typedef struct packed {
      logic [2:0]  mode;
      logic [63:0] value;
   } req_type;

   typedef struct packed {
      logic [7:0] char_code;
      logic       last_char;
   } rsp_type;

   typedef struct packed {
      prefix_type  prefix;
      radix_type   radix;
      logic [63:0] mag;
   } job_type;

   function automatic logic [7:0] digit_char(input logic [3:0] digit);
      logic [7:0] code;
      case (digit)
         4'd0:    code = 8'h30;
         4'd1:    code = 8'h31;
         4'd2:    code = 8'h32;
         4'd3:    code = 8'h33;
         4'd4:    code = 8'h34;
         4'd5:    code = 8'h35;
         4'd6:    code = 8'h36;
         4'd7:    code = 8'h37;
         4'd8:    code = 8'h38;
         4'd9:    code = 8'h39;
         4'd10:   code = 8'h61;
         4'd11:   code = 8'h62;
         4'd12:   code = 8'h63;
         4'd13:   code = 8'h64;
         4'd14:   code = 8'h65;
         default: code = 8'h66;
      endcase
      return code;
   endfunction

endpackage

@@ design/itoa_front.sv @@
// Front end: takes requests, works out radix, prefix and magnitude, and queues the jobs.
module itoa_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  itoa_pkg::req_type req_data,
   output logic              job_valid,
   output itoa_pkg::job_type job_data,
   input  logic              job_pop
);

   itoa_pkg::job_type queue_ff [itoa_pkg::QUEUE_DEPTH];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;

   itoa_pkg::job_type job_new;
   logic              job_keep;
   logic              accept;
   logic              push_q;
   logic              pop_q;
   logic [31:0]       neg_low;

   assign neg_low = ~req_data.value[31:0] + 32'd1;

   always_comb begin
      job_new  = '{prefix: itoa_pkg::PFX_NONE, radix: itoa_pkg::RADIX_DEC,
                   mag: {32'd0, req_data.value[31:0]}};
      job_keep = 1'b1;
      unique case (req_data.mode)
         itoa_pkg::MODE_SDEC: begin
            if (req_data.value[31]) begin
               job_new.prefix = itoa_pkg::PFX_MINUS;
               job_new.mag    = {32'd0, neg_low};
            end
         end
         itoa_pkg::MODE_UDEC: begin
            job_new.radix = itoa_pkg::RADIX_DEC;
         end
         itoa_pkg::MODE_OCT: begin
            job_new.radix = itoa_pkg::RADIX_OCT;
         end
         itoa_pkg::MODE_HEX: begin
            job_new.radix = itoa_pkg::RADIX_HEX;
         end
         itoa_pkg::MODE_PTR: begin
            job_new.radix  = itoa_pkg::RADIX_HEX;
            job_new.prefix = itoa_pkg::PFX_HEX;
            job_new.mag    = req_data.value;
         end
         default: begin
            // Undefined modes are taken and dropped without any text.
            job_keep = 1'b0;
         end
      endcase
   end

   assign req_full  = (count_ff == 2'(itoa_pkg::QUEUE_DEPTH));
   assign accept    = req_push && !req_full;
   assign push_q    = accept && job_keep;
   assign job_valid = (count_ff != 2'd0);
   assign pop_q     = job_pop && job_valid;
   assign job_data  = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push_q;
      rd_ptr_in = rd_ptr_ff ^ pop_q;
      count_in  = count_ff + 2'(push_q) - 2'(pop_q);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_q) begin
         queue_ff[wr_ptr_ff] <= job_new;
      end
   end

endmodule

@@ design/itoa_back.sv @@
// Back end: generates digits one per cycle onto a stack, then sends the text out.
module itoa_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   input  itoa_pkg::job_type job_data,
   output logic              job_pop,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output itoa_pkg::rsp_type rsp_data
);

   itoa_pkg::back_state_type state_ff, state_in;
   logic [63:0]              mag_ff, mag_in;
   itoa_pkg::radix_type      radix_ff;
   itoa_pkg::prefix_type     prefix_ff;
   logic [4:0]               cnt_ff, cnt_in;
   logic [3:0]               stack_ff [itoa_pkg::STACK_DEPTH];
   logic                     rsp_valid_ff, rsp_valid_in;
   itoa_pkg::rsp_type        rsp_ff, rsp_in;

   logic        out_ready;
   logic        emit;
   logic [7:0]  emit_code;
   logic        emit_last;
   logic        digit_we;
   logic [63:0] prod;
   logic [31:0] q_dec;
   logic [31:0] q_ten;
   logic [31:0] r_dec;
   logic [63:0] quot;
   logic [3:0]  digit;
   logic [4:0]  rd_idx;

   // Divide by ten through the reciprocal; the remainder comes from q * 10.
   assign prod  = mag_ff[31:0] * itoa_pkg::DEC_RECIP;
   assign q_dec = 32'(prod >> itoa_pkg::DEC_SHIFT);
   assign q_ten = {q_dec[28:0], 3'd0} + {q_dec[30:0], 1'd0};
   assign r_dec = mag_ff[31:0] - q_ten;

   always_comb begin
      case (radix_ff)
         itoa_pkg::RADIX_OCT: begin
            quot  = {3'd0, mag_ff[63:3]};
            digit = {1'b0, mag_ff[2:0]};
         end
         itoa_pkg::RADIX_HEX: begin
            quot  = {4'd0, mag_ff[63:4]};
            digit = mag_ff[3:0];
         end
         default: begin
            quot  = {32'd0, q_dec};
            digit = r_dec[3:0];
         end
      endcase
   end

   assign out_ready = !rsp_valid_ff || rsp_pop;
   assign rd_idx    = cnt_ff - 5'd1;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         itoa_pkg::ST_IDLE: begin
            if (job_valid) begin
               state_in = itoa_pkg::ST_CONV;
            end
         end
         itoa_pkg::ST_CONV: begin
            if (quot == 64'd0) begin
               case (prefix_ff)
                  itoa_pkg::PFX_MINUS: state_in = itoa_pkg::ST_SIGN;
                  itoa_pkg::PFX_HEX:   state_in = itoa_pkg::ST_ZERO;
                  default:             state_in = itoa_pkg::ST_DIGITS;
               endcase
            end
         end
         itoa_pkg::ST_SIGN: begin
            if (out_ready) begin
               state_in = itoa_pkg::ST_DIGITS;
            end
         end
         itoa_pkg::ST_ZERO: begin
            if (out_ready) begin
               state_in = itoa_pkg::ST_XCHR;
            end
         end
         itoa_pkg::ST_XCHR: begin
            if (out_ready) begin
               state_in = itoa_pkg::ST_DIGITS;
            end
         end
         itoa_pkg::ST_DIGITS: begin
            if (out_ready && cnt_ff == 5'd1) begin
               state_in = itoa_pkg::ST_IDLE;
            end
         end
         default: state_in = itoa_pkg::ST_IDLE;
      endcase
   end

   // Outputs of the sequencer.
   always_comb begin
      job_pop   = 1'b0;
      digit_we  = 1'b0;
      emit      = 1'b0;
      emit_code = itoa_pkg::CHAR_ZERO;
      emit_last = 1'b0;
      unique case (state_ff)
         itoa_pkg::ST_IDLE: begin
            job_pop = job_valid;
         end
         itoa_pkg::ST_CONV: begin
            digit_we = 1'b1;
         end
         itoa_pkg::ST_SIGN: begin
            emit      = out_ready;
            emit_code = itoa_pkg::CHAR_MINUS;
         end
         itoa_pkg::ST_ZERO: begin
            emit      = out_ready;
            emit_code = itoa_pkg::CHAR_ZERO;
         end
         itoa_pkg::ST_XCHR: begin
            emit      = out_ready;
            emit_code = itoa_pkg::CHAR_X;
         end
         itoa_pkg::ST_DIGITS: begin
            emit      = out_ready;
            emit_code = itoa_pkg::digit_char(stack_ff[rd_idx[3:0]]);
            emit_last = (cnt_ff == 5'd1);
         end
         default: begin
            job_pop = 1'b0;
         end
      endcase
   end

   always_comb begin
      mag_in = mag_ff;
      cnt_in = cnt_ff;
      if (job_pop) begin
         mag_in = job_data.mag;
         cnt_in = 5'd0;
      end else if (digit_we) begin
         mag_in = quot;
         cnt_in = cnt_ff + 5'd1;
      end else if (emit && state_ff == itoa_pkg::ST_DIGITS) begin
         cnt_in = rd_idx;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_pop;
      rsp_in       = rsp_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_in       = '{char_code: emit_code, last_char: emit_last};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= itoa_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= 5'd0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      rsp_ff <= rsp_in;
      if (job_pop) begin
         radix_ff  <= job_data.radix;
         prefix_ff <= job_data.prefix;
      end
      if (digit_we) begin
         stack_ff[cnt_ff[3:0]] <= digit;
      end
   end

   assign rsp_empty = !rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ design/integer_to_radix_ascii.sv @@
// Top level of the integer to ASCII radix formatter.
//
//   channel   ports                          carries
//   request   req_push, req_full, req_data    mode and 64-bit value
//   response  rsp_empty, rsp_pop, rsp_data    one character and its last flag
//
// A value's digits are made in the digit loop after the job is fetched (one divide
// by ten or one shift per cycle); then its prefix characters and its digits leave
// at one per cycle while the output register is not stalled.
// The two-entry job queue lets requests come in while a value is being sent.
// Reset is synchronous and empties the queue and the output register.
// A stalled pop holds the output register and the sequencer in its output states.
module integer_to_radix_ascii (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  itoa_pkg::req_type req_data,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output itoa_pkg::rsp_type rsp_data
);

   logic              job_valid;
   logic              job_pop;
   itoa_pkg::job_type job_data;

   itoa_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .job_valid (job_valid),
      .job_data  (job_data),
      .job_pop   (job_pop)
   );

   itoa_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job_data  (job_data),
      .job_pop   (job_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

@@ design/itoa_checker.sv @@
// Port-level checker for the radix formatter, bound to the top level.
`include "assert_macros.svh"

module itoa_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_empty,
   input logic              rsp_pop,
   input itoa_pkg::rsp_type rsp_data
);

   logic legal_char;
   logic prefix_char;

   assign prefix_char = rsp_data.char_code == itoa_pkg::CHAR_MINUS ||
                        rsp_data.char_code == itoa_pkg::CHAR_X;

   assign legal_char = (rsp_data.char_code >= 8'h30 && rsp_data.char_code <= 8'h39) ||
                       (rsp_data.char_code >= 8'h61 && rsp_data.char_code <= 8'h66) ||
                       prefix_char;

   `ASSERT_ALL(a_reset_empty, clock, reset |=> rsp_empty)
   `ASSERT_CLK(a_hold, clock, reset, !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_data))
   `ASSERT_CLK(a_legal_char, clock, reset, !rsp_empty |-> legal_char)
   `ASSERT_CLK(a_prefix_not_last, clock, reset, !rsp_empty && prefix_char |-> !rsp_data.last_char)

endmodule

bind integer_to_radix_ascii itoa_checker u_itoa_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop),
   .rsp_data  (rsp_data)
);

@@ test/tb_top.sv @@
// Self-checking testbench for the integer to ASCII radix formatter.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam int DRAIN_CYCLES = 40;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int RANDOM_ITEMS = 230;
   localparam int PHASE_ITEMS = 35;

   // Works out the text of each accepted value and checks the characters that come back.
   class ascii_scoreboard;
      itoa_pkg::rsp_type expected_chars[$];
      int mismatches = 0;

      function void add_value(itoa_pkg::req_type item);
         logic [63:0] mag;
         logic [63:0] radix;
         logic [7:0] text[$];
         logic [7:0] digits[$];
         logic [3:0] digit;
         itoa_pkg::rsp_type entry;
         case (item.mode)
            itoa_pkg::MODE_SDEC: begin
               radix = 64'd10;
               if (item.value[31]) begin
                  text.push_back(itoa_pkg::CHAR_MINUS);
                  mag = {32'd0, 32'd0 - item.value[31:0]};
               end else begin
                  mag = {32'd0, item.value[31:0]};
               end
            end
            itoa_pkg::MODE_UDEC: begin
               radix = 64'd10;
               mag = {32'd0, item.value[31:0]};
            end
            itoa_pkg::MODE_OCT: begin
               radix = 64'd8;
               mag = {32'd0, item.value[31:0]};
            end
            itoa_pkg::MODE_HEX: begin
               radix = 64'd16;
               mag = {32'd0, item.value[31:0]};
            end
            itoa_pkg::MODE_PTR: begin
               radix = 64'd16;
               mag = item.value;
               text.push_back(itoa_pkg::CHAR_ZERO);
               text.push_back(itoa_pkg::CHAR_X);
            end
            default: begin
               // The unused modes produce no text at all.
               return;
            end
         endcase
         do begin
            digit = 4'(mag % radix);
            digits.push_front(digit < 4'd10 ? itoa_pkg::CHAR_ZERO + 8'(digit)
                                            : CHAR_LOWER_A + 8'(digit) - 8'd10);
            mag = mag / radix;
         end while (mag != 64'd0);
         foreach (digits[i]) text.push_back(digits[i]);
         foreach (text[i]) begin
            entry.char_code = text[i];
            entry.last_char = (i == text.size() - 1);
            expected_chars.push_back(entry);
         end
      endfunction

      function void report(string msg);
         mismatches++;
         $display("%0t ns: %s", $time, msg);
      endfunction

      function void check_char(itoa_pkg::rsp_type got);
         itoa_pkg::rsp_type want;
         if (expected_chars.size() == 0) begin
            report($sformatf("char %h last %b with nothing expected",
                             got.char_code, got.last_char));
            return;
         end
         want = expected_chars.pop_front();
         if (got.char_code !== want.char_code)
            report($sformatf("char_code expected %h actual %h",
                             want.char_code, got.char_code));
         if (got.last_char !== want.last_char)
            report($sformatf("last_char expected %b actual %b (char %h)",
                             want.last_char, got.last_char, want.char_code));
      endfunction

      function int outstanding();
         return expected_chars.size();
      endfunction

      function void check_leftovers();
         if (expected_chars.size() != 0)
            report($sformatf("%0d expected chars never arrived", expected_chars.size()));
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset;
   logic              req_push;
   logic              req_full;
   itoa_pkg::req_type req_data;
   logic              rsp_empty;
   logic              rsp_pop;
   itoa_pkg::rsp_type rsp_data;

   ascii_scoreboard board = new();

   bit rx_enabled = 1'b0;
   bit rx_steady = 1'b0;
   bit tx_steady = 1'b0;
   bit hold_request = 1'b0;

   integer_to_radix_ascii dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_push && !req_full) board.add_value(req_data);
         if (rsp_pop && !rsp_empty) board.check_char(rsp_data);
      end
   end

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 40) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [63:0] pick_value();
      logic [63:0] v;
      logic [31:0] p;
      v = {$urandom, $urandom};
      case ($urandom_range(0, 5))
         0: v = v;
         1: v = v >> $urandom_range(1, 63);
         2: v = 64'($urandom_range(0, 20));
         3: v = ~64'($urandom_range(0, 20));
         4: v = (64'd1 << $urandom_range(0, 63)) - 64'($urandom_range(0, 1));
         default: begin
            // Powers of ten and the values just below them move the decimal digit count.
            p = 32'd1;
            repeat ($urandom_range(0, 9)) p = p * 32'd10;
            v[31:0] = p - 32'($urandom_range(0, 1));
         end
      endcase
      return v;
   endfunction

   task automatic send_value(input logic [2:0] mode, input logic [63:0] value);
      int gap;
      req_data <= '{mode: mode, value: value};
      req_push <= 1'b1;
      do @(posedge clock); while (req_full);
      gap = tx_steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Lets every expected character drain, then covers the latency of ignored items.
   task automatic wait_idle();
      req_push <= 1'b0;
      @(posedge clock);
      while (board.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin : receiver
      int hold;
      hold = 0;
      wait (rx_enabled);
      forever begin
         @(posedge clock);
         if (hold > 0) begin
            rsp_pop <= 1'b0;
            hold--;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold = LONG_HOLD_CYCLES - 1;
            rsp_pop <= 1'b0;
         end else if (!rx_steady && $urandom_range(0, 3) == 0) begin
            hold = pick_gap();
            rsp_pop <= (hold == 0);
            if (hold > 0) hold--;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   initial begin
      #20ms;
      $display("tb_top: done, errors");
      $finish;
   end

   initial begin : stimulus
      int sent;
      int phase;
      int in_phase;
      logic [2:0] mode;
      reset = 1'b1;
      req_push = 1'b0;
      req_data = '0;
      rsp_pop = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      rx_enabled = 1'b1;

      // Directed: zero, sign handling, the most negative value, full-width patterns.
      send_value(itoa_pkg::MODE_SDEC, 64'd0);
      send_value(itoa_pkg::MODE_SDEC, 64'd10);
      send_value(itoa_pkg::MODE_SDEC, 64'h0000_0000_ffff_ffff);
      send_value(itoa_pkg::MODE_SDEC, 64'h0000_0000_7fff_ffff);
      send_value(itoa_pkg::MODE_SDEC, 64'h0000_0000_8000_0000);
      send_value(itoa_pkg::MODE_SDEC, 64'hdead_beef_0000_0007);
      send_value(itoa_pkg::MODE_UDEC, 64'd0);
      send_value(itoa_pkg::MODE_UDEC, 64'hffff_ffff_ffff_ffff);
      send_value(itoa_pkg::MODE_UDEC, 64'd1_000_000_000);
      send_value(itoa_pkg::MODE_OCT, 64'd0);
      send_value(itoa_pkg::MODE_OCT, 64'd8);
      send_value(itoa_pkg::MODE_OCT, 64'h0000_0000_ffff_ffff);
      send_value(itoa_pkg::MODE_HEX, 64'd0);
      send_value(itoa_pkg::MODE_HEX, 64'h1234_5678_0000_abcd);
      send_value(itoa_pkg::MODE_HEX, 64'h0000_0000_ffff_ffff);
      send_value(itoa_pkg::MODE_PTR, 64'd0);
      send_value(itoa_pkg::MODE_PTR, 64'd1);
      send_value(itoa_pkg::MODE_PTR, 64'h8000_0000_0000_0000);
      send_value(itoa_pkg::MODE_PTR, 64'hffff_ffff_ffff_ffff);
      send_value(3'd5, 64'hffff_ffff_ffff_ffff);
      send_value(3'd6, 64'd0);
      send_value(3'd7, 64'h5555_aaaa_5555_aaaa);
      wait_idle();

      sent = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         tx_steady = (phase % 3 == 1) || (phase == 2);
         rx_steady = (phase % 4 == 3);
         // Phase two stalls the receiver so the job queue fills and pushes back.
         if (phase == 2) hold_request = 1'b1;
         // Phase four starts only after the block has gone completely idle.
         if (phase == 4) wait_idle();
         in_phase = 0;
         while (in_phase < PHASE_ITEMS && sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 19) < 18) begin
               mode = 3'($urandom_range(0, 4));
               sent++;
               in_phase++;
            end else begin
               mode = 3'($urandom_range(5, 7));
            end
            send_value(mode, pick_value());
         end
         phase++;
      end

      wait_idle();
      board.check_leftovers();
      if (board.mismatches == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+design
design/itoa_pkg.sv
design/itoa_front.sv
design/itoa_back.sv
design/integer_to_radix_ascii.sv
design/itoa_checker.sv
test/tb_top.sv
